// ===== src/red_hue_alpha_mask_pixel_core_defines.svh =====
// Assertion macros shared by the red color-key mask checker.
`ifndef RED_HUE_ALPHA_MASK_PIXEL_CORE_DEFINES_SVH
`define RED_HUE_ALPHA_MASK_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RHAM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, also checked across reset.
`define RHAM_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/rham_pkg.sv =====
// Types and constants of the red color-key mask pipeline.
package rham_pkg;

   typedef enum logic [1:0] {
      CSR_CHANNEL_ORDER,
      CSR_MIN_SAT,
      CSR_MAX_SAT,
      CSR_VALUE_MIN
   } csr_index_type;

   localparam logic       RESET_CHANNEL_ORDER = 1'b0;
   localparam logic [7:0] RESET_MIN_SAT       = 8'd15;
   localparam logic [7:0] RESET_MAX_SAT       = 8'd30;
   localparam logic [7:0] RESET_VALUE_MIN     = 8'd50;
   localparam logic [7:0] CHAN_FULL           = 8'd255;
   localparam logic [7:0] CHAN_ZERO           = 8'd0;
   localparam logic [7:0] ALPHA_MAX           = 8'd255;

   typedef struct packed {
      logic       channel_order;
      logic [7:0] min_sat;
      logic [7:0] max_sat;
      logic [7:0] value_min;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } pix_type;

   // Classifier result: pixel, mask hit and saturation above threshold.
   typedef struct packed {
      pix_type    pix;
      logic       hit;
      logic [7:0] span;
   } cls_type;

   // Division state carried down the divider stages.
   typedef struct packed {
      pix_type    pix;
      logic       hit;
      logic       clamp;
      logic [7:0] rem;
      logic [7:0] low;
      logic [7:0] quo;
   } div_type;

endpackage

// ===== src/rham_ifs.sv =====
// Channel interfaces: pixel in, pixel out and register write.
interface rham_pixel_in_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan_first;
   logic [7:0] chan_second;
   logic [7:0] chan_third;
   logic       frame_end;

   modport source (output valid, output chan_first, output chan_second,
                   output chan_third, output frame_end, input ready);
   modport sink   (input valid, input chan_first, input chan_second,
                   input chan_third, input frame_end, output ready);
endinterface

interface rham_pixel_out_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       frame_end_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output alpha_out, output frame_end_out, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input alpha_out, input frame_end_out, output ready);
endinterface

interface rham_csr_if;
   logic                   valid;
   logic                   ready;
   rham_pkg::csr_index_type index;
   logic [7:0]             data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/red_hue_alpha_mask_pixel_core.sv =====
// Red color-key alpha mask: one RGB/BGR pixel in, one RGBA pixel out.
//
// req_if carries one pixel per transfer (chan_first, chan_second, chan_third,
// frame_end); rsp_if returns the pixel reordered to red, green, blue plus the
// alpha byte and the frame marker. csr_if writes the four registers (channel
// order, min_sat, max_sat, value_min) by index; write only while no pixel is
// in flight.
// Throughput is one pixel per cycle while rsp_if is not stalled. A pixel accepted
// on req_if loads the classify register, then passes one scaling stage, four
// divider stages that resolve two quotient bits each, and the output register
// before it shows on rsp_if.
// Reset empties the pipeline and loads the register defaults (RGB order,
// min_sat 15, max_sat 30, value_min 50).
// When the receiver holds rsp_if.ready low with a result waiting, every stage
// holds and req_if.ready drops in the same cycle; nothing is dropped or
// repeated. Bubbles in the input stream pass through as bubbles.
module red_hue_alpha_mask_pixel_core (
   input  logic                    clock,
   input  logic                    reset,
   rham_pixel_in_if.sink           req_if,
   rham_pixel_out_if.source        rsp_if,
   rham_csr_if.sink                csr_if
);

   rham_pkg::cfg_type cfg_ff;
   rham_pkg::cfg_type cfg_in;
   logic              en;
   logic              cls_valid;
   rham_pkg::cls_type cls_data;
   logic              div_valid;
   rham_pkg::div_type div_data;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rham_pkg::pix_type rsp_pix_ff;
   logic [7:0]        rsp_alpha_ff;
   logic [7:0]        rsp_alpha_in;

   // Advance the whole pipeline unless a finished pixel is stuck at the output.
   assign en = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            rham_pkg::CSR_CHANNEL_ORDER: cfg_in.channel_order = csr_if.data[0];
            rham_pkg::CSR_MIN_SAT:       cfg_in.min_sat = csr_if.data;
            rham_pkg::CSR_MAX_SAT:       cfg_in.max_sat = csr_if.data;
            rham_pkg::CSR_VALUE_MIN:     cfg_in.value_min = csr_if.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_order <= rham_pkg::RESET_CHANNEL_ORDER;
         cfg_ff.min_sat <= rham_pkg::RESET_MIN_SAT;
         cfg_ff.max_sat <= rham_pkg::RESET_MAX_SAT;
         cfg_ff.value_min <= rham_pkg::RESET_VALUE_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rham_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_if.valid),
      .chan_first  (req_if.chan_first),
      .chan_second (req_if.chan_second),
      .chan_third  (req_if.chan_third),
      .frame_end   (req_if.frame_end),
      .cfg         (cfg_ff),
      .out_valid   (cls_valid),
      .out_data    (cls_data)
   );

   rham_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cls_valid),
      .in_data   (cls_data),
      .max_sat   (cfg_ff.max_sat),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   always_comb begin
      rsp_valid_in = div_valid;
      if (!div_data.hit) begin
         rsp_alpha_in = 8'd0;
      end else if (div_data.clamp) begin
         rsp_alpha_in = rham_pkg::ALPHA_MAX;
      end else begin
         rsp_alpha_in = div_data.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pix_ff <= div_data.pix;
         rsp_alpha_ff <= rsp_alpha_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.red_out = rsp_pix_ff.red;
   assign rsp_if.green_out = rsp_pix_ff.green;
   assign rsp_if.blue_out = rsp_pix_ff.blue;
   assign rsp_if.alpha_out = rsp_alpha_ff;
   assign rsp_if.frame_end_out = rsp_pix_ff.frame_end;

endmodule

// ===== src/rham_classify.sv =====
// First pipeline stage: channel order, max/min, hue window and thresholds.
module rham_classify (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [7:0]        chan_first,
   input  logic [7:0]        chan_second,
   input  logic [7:0]        chan_third,
   input  logic              frame_end,
   input  rham_pkg::cfg_type cfg,
   output logic              out_valid,
   output rham_pkg::cls_type out_data
);

   logic              valid_ff;
   rham_pkg::cls_type data_ff;
   rham_pkg::cls_type data_in;
   logic [7:0]        red;
   logic [7:0]        blue;
   logic [7:0]        mx;
   logic [7:0]        mn;
   logic [7:0]        sat;
   logic              red_max;
   logic              hue_edge;

   always_comb begin
      red = cfg.channel_order ? chan_third : chan_first;
      blue = cfg.channel_order ? chan_first : chan_third;
      mx = red;
      mn = red;
      if (chan_second > mx) mx = chan_second;
      if (blue > mx) mx = blue;
      if (chan_second < mn) mn = chan_second;
      if (blue < mn) mn = blue;
      sat = mx - mn;
      // Only the red sector can reach the window above 300 or below 60 degrees;
      // it misses exactly when green and blue differ by the full byte range.
      red_max = (red >= chan_second) && (red >= blue);
      hue_edge = ((chan_second == rham_pkg::CHAN_FULL) && (blue == rham_pkg::CHAN_ZERO)) ||
                 ((chan_second == rham_pkg::CHAN_ZERO) && (blue == rham_pkg::CHAN_FULL));
      data_in.pix.red = red;
      data_in.pix.green = chan_second;
      data_in.pix.blue = blue;
      data_in.pix.frame_end = frame_end;
      data_in.hit = (sat > cfg.min_sat) && red_max && !hue_edge && (mx > cfg.value_min);
      data_in.span = sat - cfg.min_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ===== src/rham_divider.sv =====
// Alpha scaling: span*255 then a restoring divide by max_sat, two bits per stage.
module rham_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rham_pkg::cls_type in_data,
   input  logic [7:0]        max_sat,
   output logic              out_valid,
   output rham_pkg::div_type out_data
);

   localparam int DIV_STAGES = 4;
   localparam int STEPS_PER_STAGE = 2;

   logic                      prep_valid_ff;
   rham_pkg::div_type         prep_ff;
   rham_pkg::div_type         prep_in;
   logic [15:0]               product;
   logic [DIV_STAGES-1:0]     stage_valid_ff;
   rham_pkg::div_type         stage_ff [DIV_STAGES];
   rham_pkg::div_type         stage_in [DIV_STAGES];

   function automatic rham_pkg::div_type div_step(input rham_pkg::div_type d,
                                                  input logic [7:0] m);
      logic [8:0]        t;
      logic [8:0]        diff;
      rham_pkg::div_type o;
      o = d;
      t = {d.rem, d.low[7]};
      diff = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
         o.rem = diff[7:0];
         o.quo = {d.quo[6:0], 1'b1};
      end else begin
         o.rem = t[7:0];
         o.quo = {d.quo[6:0], 1'b0};
      end
      o.low = {d.low[6:0], 1'b0};
      return o;
   endfunction

   always_comb begin
      product = {in_data.span, 8'h00} - {8'h00, in_data.span};
      prep_in.pix = in_data.pix;
      prep_in.hit = in_data.hit;
      // Quotient of 256 or more saturates; a zero divisor saturates too.
      prep_in.clamp = (max_sat == 8'd0) || (product >= {max_sat, 8'h00});
      prep_in.rem = product[15:8];
      prep_in.low = product[7:0];
      prep_in.quo = 8'd0;
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_in[s] = (s == 0) ? prep_ff : stage_ff[(s == 0) ? 0 : s - 1];
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            stage_in[s] = div_step(stage_in[s], max_sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
         stage_valid_ff <= '0;
      end else if (en) begin
         prep_valid_ff <= in_valid;
         stage_valid_ff <= {stage_valid_ff[DIV_STAGES-2:0], prep_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
         for (int s = 0; s < DIV_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid = stage_valid_ff[DIV_STAGES-1];
   assign out_data = stage_ff[DIV_STAGES-1];

endmodule

// ===== src/rham_checker.sv =====
// Port-level checks of the red color-key mask core, bound to the top level.
`include "red_hue_alpha_mask_pixel_core_defines.svh"

module rham_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha,
   input logic       rsp_frame_end
);

   logic        rsp_stall;
   logic        red_dominant;
   logic [32:0] rsp_payload;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_frame_end};
   assign red_dominant = (rsp_red >= rsp_green) && (rsp_red >= rsp_blue) &&
                         ((rsp_red != rsp_green) || (rsp_red != rsp_blue));

   // A stalled result holds until its transfer.
   `RHAM_ASSERT_NEXT(a_rsp_hold, clock, (!reset && rsp_stall), (rsp_valid && $stable(rsp_payload)))

   // Reset empties the pipeline.
   `RHAM_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // Input back-pressure comes only from a stalled output.
   `RHAM_ASSERT_NOW(a_ready_on_stall, clock, reset, !req_ready, rsp_stall)

   // A nonzero mask needs red at least as large as green and blue, the three not all equal.
   `RHAM_ASSERT_NOW(a_alpha_red_key, clock, reset, (rsp_valid && rsp_alpha != 8'd0), red_dominant)

endmodule

bind red_hue_alpha_mask_pixel_core rham_checker u_rham_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_red       (rsp_if.red_out),
   .rsp_green     (rsp_if.green_out),
   .rsp_blue      (rsp_if.blue_out),
   .rsp_alpha     (rsp_if.alpha_out),
   .rsp_frame_end (rsp_if.frame_end_out)
);

// ===== tb/tb_red_hue_alpha_mask_pixel_core.sv =====
// Self-checking bench for the red color-key mask core: directed table, random pixels, idling.
module tb_red_hue_alpha_mask_pixel_core;

   localparam int DRAIN_CYCLES   = 10;
   localparam int END_CYCLES     = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_PIXELS   = 36;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       frame_end;
   } mask_result_type;

   typedef struct packed {
      logic [7:0]      first;
      logic [7:0]      second;
      logic [7:0]      third;
      logic            frame_end;
      logic            pinned;
      mask_result_type pinned_res;
   } pixel_req_type;

   typedef struct {
      rham_pkg::cfg_type cfg;
      pixel_req_type     px;
   } dir_row_type;

   localparam rham_pkg::cfg_type DEF_CFG  = '{rham_pkg::RESET_CHANNEL_ORDER,
                                              rham_pkg::RESET_MIN_SAT,
                                              rham_pkg::RESET_MAX_SAT,
                                              rham_pkg::RESET_VALUE_MIN};
   localparam rham_pkg::cfg_type BGR_OPEN = '{1'b1, 8'd0, 8'd0, 8'd0};
   localparam rham_pkg::cfg_type SHUT_CFG = '{1'b0, 8'd255, 8'd255, 8'd255};

   logic clock;
   logic reset;

   rham_pixel_in_if  req_if();
   rham_pixel_out_if rsp_if();
   rham_csr_if       csr_if();

   red_hue_alpha_mask_pixel_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   rham_pkg::cfg_type mask_cfg;
   idle_mode_type     idle_mode;
   pixel_req_type     pixel_q[$];
   mask_result_type   mask_expect_q[$];
   dir_row_type       dir_tab[$];
   int                fail_count;
   int                result_count;
   int                stall_cycles;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic mask_result_type predict_mask(rham_pkg::cfg_type c, pixel_req_type p);
      mask_result_type res;
      int r, g, b, mx, mn, sat, base, d, hue, a;
      r = c.channel_order ? p.third : p.first;
      g = p.second;
      b = c.channel_order ? p.first : p.third;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sat = mx - mn;
      // red wins ties over green, green over blue
      if (mx == r) begin
         base = 0;
         d = g - b;
      end else if (mx == g) begin
         base = 120;
         d = b - r;
      end else begin
         base = 240;
         d = r - g;
      end
      hue = (base * 255 + 60 * d) / 255;
      if (hue < 0) hue += 360;
      a = 0;
      if (sat > int'(c.min_sat) && (hue > 300 || hue < 60) && mx > int'(c.value_min)) begin
         if (c.max_sat == 8'd0) begin
            a = 255;
         end else begin
            a = ((sat - int'(c.min_sat)) * 255) / int'(c.max_sat);
            if (a > 255) a = 255;
         end
      end
      res.red       = r[7:0];
      res.green     = g[7:0];
      res.blue      = b[7:0];
      res.alpha     = a[7:0];
      res.frame_end = p.frame_end;
      return res;
   endfunction

   function automatic mask_result_type pixel_expect(pixel_req_type p);
      if (p.pinned) return p.pinned_res;
      return predict_mask(mask_cfg, p);
   endfunction

   function automatic dir_row_type drow(rham_pkg::cfg_type c, logic [7:0] f, logic [7:0] s,
                                        logic [7:0] t, logic fe, logic pin, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, logic [7:0] a);
      dir_row_type row;
      row.cfg = c;
      row.px  = '{f, s, t, fe, pin, '{r, g, b, a, fe}};
      return row;
   endfunction

   function automatic pixel_req_type random_pixel(rham_pkg::cfg_type c);
      pixel_req_type p;
      logic [7:0] r, g, b;
      int kind;
      kind = $urandom_range(0, 9);
      r = 8'($urandom_range(0, 255));
      // mostly red-dominant pixels so the hue and threshold tests see hits
      if (kind < 6) begin
         g = 8'($urandom_range(0, r));
         b = 8'($urandom_range(0, r));
      end else begin
         g = 8'($urandom);
         b = 8'($urandom);
      end
      p.first      = c.channel_order ? b : r;
      p.second     = g;
      p.third      = c.channel_order ? r : b;
      p.frame_end  = ($urandom_range(0, 15) == 0);
      p.pinned     = 1'b0;
      p.pinned_res = '0;
      return p;
   endfunction

   function automatic rham_pkg::cfg_type phase_cfg(int k);
      rham_pkg::cfg_type c;
      case (k)
         0: c = '{1'b0, 8'd0, 8'd0, 8'd0};
         1: c = '{1'b1, 8'd255, 8'd255, 8'd255};
         2: c = '{1'b1, 8'd15, 8'd30, 8'd50};
         3: c = '{1'b0, 8'd0, 8'd255, 8'd0};
         default: begin
            c.channel_order = 1'($urandom_range(0, 1));
            c.min_sat   = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom);
            c.max_sat   = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
            c.value_min = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 100) : $urandom);
         end
      endcase
      return c;
   endfunction

   function automatic logic gap_draw(logic is_sender);
      case (idle_mode)
         IDLE_SENDER:   return is_sender && ($urandom_range(0, 99) < 75);
         IDLE_RECEIVER: return !is_sender && ($urandom_range(0, 99) < 75);
         IDLE_BOTH:     return $urandom_range(0, 99) < 32;
         default:       return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at result %0d: %s", result_count, msg);
      fail_count++;
   endtask

   task automatic write_reg(rham_pkg::csr_index_type idx, logic [7:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      case (idx)
         rham_pkg::CSR_CHANNEL_ORDER: mask_cfg.channel_order = val[0];
         rham_pkg::CSR_MIN_SAT:       mask_cfg.min_sat       = val;
         rham_pkg::CSR_MAX_SAT:       mask_cfg.max_sat       = val;
         rham_pkg::CSR_VALUE_MIN:     mask_cfg.value_min     = val;
         default: ;
      endcase
   endtask

   task automatic apply_cfg(rham_pkg::cfg_type c);
      // write registers only with the pipeline empty
      while (pixel_q.size() != 0 || mask_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(rham_pkg::CSR_CHANNEL_ORDER, {7'd0, c.channel_order});
      write_reg(rham_pkg::CSR_MIN_SAT, c.min_sat);
      write_reg(rham_pkg::CSR_MAX_SAT, c.max_sat);
      write_reg(rham_pkg::CSR_VALUE_MIN, c.value_min);
      csr_if.valid <= 1'b0;
   endtask

   // Pixel source: record the expectation on each transfer, hold while stalled.
   always @(posedge clock) begin : pixel_driver
      logic hold;
      if (!reset && req_if.valid && req_if.ready) begin
         mask_expect_q.push_back(pixel_expect(pixel_q.pop_front()));
      end
      hold = !reset && req_if.valid && !req_if.ready;
      if (!hold) begin
         if (!reset && pixel_q.size() != 0 && !gap_draw(1'b1)) begin
            req_if.valid       <= 1'b1;
            req_if.chan_first  <= pixel_q[0].first;
            req_if.chan_second <= pixel_q[0].second;
            req_if.chan_third  <= pixel_q[0].third;
            req_if.frame_end   <= pixel_q[0].frame_end;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result sink: compare each transfer against the oldest expectation.
   always @(posedge clock) begin : result_check
      mask_result_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out, rsp_if.alpha_out,
                 rsp_if.frame_end_out};
         if (mask_expect_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = mask_expect_q.pop_front();
            if (got.red !== want.red)
               report_mismatch($sformatf("red_out %0d, want %0d", got.red, want.red));
            if (got.green !== want.green)
               report_mismatch($sformatf("green_out %0d, want %0d", got.green, want.green));
            if (got.blue !== want.blue)
               report_mismatch($sformatf("blue_out %0d, want %0d", got.blue, want.blue));
            if (got.alpha !== want.alpha)
               report_mismatch($sformatf("alpha_out %0d, want %0d", got.alpha, want.alpha));
            if (got.frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end_out %0b, want %0b", got.frame_end,
                                         want.frame_end));
         end
         result_count++;
      end
      rsp_if.ready <= !reset && !gap_draw(1'b0);
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int k, n;
      reset        <= 1'b1;
      csr_if.valid <= 1'b0;
      csr_if.index <= rham_pkg::CSR_CHANNEL_ORDER;
      csr_if.data  <= 8'd0;
      idle_mode    = IDLE_BOTH;
      mask_cfg     = DEF_CFG;

      // register defaults after reset
      dir_tab.push_back(drow(DEF_CFG, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
                             8'd255, 8'd255, 8'd255, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1,
                             8'd255, 8'd0, 8'd0, rham_pkg::ALPHA_MAX));
      dir_tab.push_back(drow(DEF_CFG, 8'd0, 8'd255, 8'd0, 1'b0, 1'b1,
                             8'd0, 8'd255, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1,
                             8'd0, 8'd0, 8'd255, 8'd0));
      // red and blue tie: hue lands exactly on 300, a miss
      dir_tab.push_back(drow(DEF_CFG, 8'd255, 8'd0, 8'd255, 1'b0, 1'b1,
                             8'd255, 8'd0, 8'd255, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd255, 8'd0, 8'd254, 1'b0, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));
      // red and green tie: hue exactly 60, a miss
      dir_tab.push_back(drow(DEF_CFG, 8'd255, 8'd255, 8'd0, 1'b0, 1'b1,
                             8'd255, 8'd255, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd255, 8'd254, 8'd0, 1'b0, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd50, 8'd0, 8'd0, 1'b0, 1'b1, 8'd50, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd51, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd100, 8'd85, 8'd85, 1'b0, 1'b1,
                             8'd100, 8'd85, 8'd85, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd100, 8'd84, 8'd84, 1'b0, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd100, 8'd80, 8'd80, 1'b0, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd0, 8'd200, 8'd200, 1'b0, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(DEF_CFG, 8'd200, 8'd60, 8'd200, 1'b1, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));
      // BGR order with zero thresholds and zero max_sat
      dir_tab.push_back(drow(BGR_OPEN, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1,
                             8'd255, 8'd0, 8'd0, rham_pkg::ALPHA_MAX));
      dir_tab.push_back(drow(BGR_OPEN, 8'd10, 8'd0, 8'd0, 1'b0, 1'b1,
                             8'd0, 8'd0, 8'd10, 8'd0));
      dir_tab.push_back(drow(BGR_OPEN, 8'd0, 8'd0, 8'd1, 1'b1, 1'b1,
                             8'd1, 8'd0, 8'd0, rham_pkg::ALPHA_MAX));
      dir_tab.push_back(drow(BGR_OPEN, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      // thresholds at the top: nothing can hit
      dir_tab.push_back(drow(SHUT_CFG, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1,
                             8'd255, 8'd0, 8'd0, 8'd0));
      dir_tab.push_back(drow(SHUT_CFG, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0,
                             8'd0, 8'd0, 8'd0, 8'd0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < dir_tab.size(); k++) begin
         if (dir_tab[k].cfg != mask_cfg) apply_cfg(dir_tab[k].cfg);
         pixel_q.push_back(dir_tab[k].px);
      end

      for (k = 0; k < PHASE_COUNT; k++) begin
         apply_cfg(phase_cfg(k));
         idle_mode = idle_mode_type'(k % 4);
         for (n = 0; n < PHASE_PIXELS; n++) pixel_q.push_back(random_pixel(mask_cfg));
      end

      while (pixel_q.size() != 0 || mask_expect_q.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
